// ----- src/hbcd_pkg.sv -----
// Package for the H-bridge calibrate-and-drive block.
// Holds field widths, command, phase and register codes, and the angle wrap function.
// Depends on nothing; every other file imports it.
`default_nettype none

package hbcd_pkg;

    // Field widths
    localparam int ANGLE_W = 17;
    localparam int NOW_W   = 32;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 3;
    localparam int TOUT_W  = 5;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SENSOR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TARGET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    // Sequence phases, as reported on the result channel
    localparam logic [PHASE_W-1:0] PH_NONE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TO_V = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TO_H = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CAL = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FAIL = 3'd6;
    localparam logic [PHASE_W-1:0] PH_OK = 3'd7;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_REVERSE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    // Angles in hundredths of a degree
    localparam int TURN        = 36000;
    localparam int HALF_TURN   = 18000;
    localparam int DEADBAND    = 50;
    localparam int MOTION_STEP = 10;
    localparam int STILL_MS    = 1000;
    localparam int MS_PER_S    = 1000;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [ANGLE_W:0]   angle_diff_t;

    // Remainder of a non-negative value below nine turns, by one turn.
    // The quotient comes from eight independent compares against constant multiples.
    function automatic logic [15:0] mod_turn(input logic [18:0] y);
        logic [3:0]  q;
        logic [18:0] r;
        q = 4'd0;
        for (int i = 1; i <= 8; i++)
        begin
            if (y >= 19'(i * TURN))
            begin
                q = 4'(i);
            end
        end
        r = y - 19'(int'(q) * TURN);
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/hbcd_if.sv -----
// Valid/ready channel interfaces for the H-bridge calibrate-and-drive block.
// One carries input items, the other result items. Depends on hbcd_pkg.
`default_nettype none

interface hbcd_item_if;
    import hbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [NOW_W-1:0]   now_ms;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output command, output now_ms, output angle,
                    input ready);
    modport sink   (input valid, input command, input now_ms, input angle,
                    output ready);
endinterface

interface hbcd_result_if;
    import hbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               drive_a;
    logic               drive_b;
    logic               moving;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output drive_a, output drive_b, output moving,
                    output phase, input ready);
    modport sink   (input valid, input drive_a, input drive_b, input moving,
                    input phase, output ready);
endinterface

`default_nettype wire

// ----- src/hbridge_calibrate_and_drive_top.sv -----
// Top level of the H-bridge calibrate-and-drive block.
// Uses hbcd_pkg and the channel interfaces in hbcd_if.sv.
//
// Usage:
//   Input items (command, now_ms, angle) arrive on the item channel: ticks,
//   sensor angles, target angles and calibration restarts. Every item yields
//   exactly one result (drive_a, drive_b, moving, phase) on the result channel,
//   showing the pin levels and phase after that item.
//   Registers enable, reverse_drive and calibration_timeout_s sit on the APB
//   port at byte addresses 0, 4 and 8; pready is always high.
// Timing:
//   An item is captured in the input register on its transfer, then processed,
//   once the output register is free or being emptied, by the compare/add logic
//   and the constant angle wrap; its result is held in the output register.
//   One item is taken every cycle while results are taken; the state registers
//   update in the same cycle as the result register, so consecutive items see
//   each other's effect with no gap.
// Reset and stall:
//   rst_n clears the sequence to the starting phase, the pins to off and the
//   registers to their defaults. When the receiver holds off the result, the
//   result waits in the output register, one more item waits in the input
//   register, and then item ready drops until the result is taken.
`default_nettype none

module hbridge_calibrate_and_drive_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hbcd_item_if.sink                          item,
    hbcd_result_if.source                      result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hbcd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hbcd_pkg::DATA_W-1:0]   pwdata,
    output logic      [hbcd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import hbcd_pkg::*;

    // Configuration registers
    logic              enable_reg;
    logic              reverse_reg;
    logic [TOUT_W-1:0] timeout_reg;

    // Input register
    logic             s1_valid_reg;
    logic [CMD_W-1:0] s1_cmd_reg;
    logic [NOW_W-1:0] s1_now_reg;
    angle_t           s1_angle_reg;

    // Block state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    angle_t             cur_reg, cur_next;
    logic               avalid_reg, avalid_next;
    angle_t             prev_reg, prev_next;
    angle_t             target_reg, target_next;
    angle_t             vend_reg, vend_next;
    angle_t             hend_reg, hend_next;
    logic [NOW_W-1:0]   pstart_reg, pstart_next;
    logic [NOW_W-1:0]   lchange_reg, lchange_next;
    logic               dir_reg, dir_next;
    logic               pin_a_reg, pin_a_next;
    logic               pin_b_reg, pin_b_next;
    logic               pin_mv_reg, pin_mv_next;

    // Output register
    logic               out_valid_reg;
    logic               out_a_reg;
    logic               out_b_reg;
    logic               out_mv_reg;
    logic [PHASE_W-1:0] out_phase_reg;

    logic fire;
    logic wr_en;

    // Working values for one item
    logic [14:0]      limit;
    logic [NOW_W-1:0] el_start;
    logic [NOW_W-1:0] el_change;
    logic             phase_exp;
    logic             expired;
    angle_diff_t      mot_d;
    logic [ANGLE_W:0] mot_abs;
    angle_diff_t      drv_d;
    logic [ANGLE_W:0] drv_abs;
    angle_diff_t      gap_d;
    logic [ANGLE_W:0] gap;
    logic             v_lt_h;
    angle_diff_t      rel;
    logic signed [19:0] ysum;
    logic [15:0]      turn_rem;

    // APB register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            reverse_reg <= 1'b0;
            timeout_reg <= 5'd15;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ENABLE:  enable_reg  <= pwdata[0];
                REG_REVERSE: reverse_reg <= pwdata[0];
                REG_TIMEOUT: timeout_reg <= pwdata[TOUT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            REG_REVERSE: prdata = {31'd0, reverse_reg};
            REG_TIMEOUT: prdata = {27'd0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    // Channel handshakes: the item in the input register is processed when the
    // output register is free or is being emptied in the same cycle.
    assign fire       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_cmd_reg   <= item.command;
            s1_now_reg   <= item.now_ms;
            s1_angle_reg <= item.angle;
        end
    end

    // Timers and distances used by the calibration and drive phases.
    always_comb
    begin
        limit     = 15'({10'd0, timeout_reg} * 15'(MS_PER_S));
        el_start  = s1_now_reg - pstart_reg;
        el_change = s1_now_reg - lchange_reg;
        phase_exp = el_start >= {17'd0, limit};
        expired   = phase_exp || (el_change >= 32'(STILL_MS));

        mot_d   = angle_diff_t'(cur_reg) - angle_diff_t'(prev_reg);
        mot_abs = mot_d[ANGLE_W] ? 18'(-mot_d) : 18'(mot_d);

        drv_d   = angle_diff_t'(target_reg) - angle_diff_t'(cur_reg);
        drv_abs = drv_d[ANGLE_W] ? 18'(-drv_d) : 18'(drv_d);

        gap_d   = angle_diff_t'(vend_reg) - angle_diff_t'(hend_reg);
        gap     = gap_d[ANGLE_W] ? 18'(-gap_d) : 18'(gap_d);
        v_lt_h  = vend_reg < hend_reg;
    end

    // Remap of a sensor angle after success: offset by four and a half turns so the
    // wrap input is never negative, then take the remainder by one turn.
    always_comb
    begin
        rel      = dir_reg ? angle_diff_t'(hend_reg) - angle_diff_t'(s1_angle_reg)
                           : angle_diff_t'(s1_angle_reg) - angle_diff_t'(hend_reg);
        ysum     = 20'(rel) + 20'sd162000;
        turn_rem = mod_turn(ysum[18:0]);
    end

    // Next state for the item in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        avalid_next  = avalid_reg;
        prev_next    = prev_reg;
        target_next  = target_reg;
        vend_next    = vend_reg;
        hend_next    = hend_reg;
        pstart_next  = pstart_reg;
        lchange_next = lchange_reg;
        dir_next     = dir_reg;
        pin_a_next   = pin_a_reg;
        pin_b_next   = pin_b_reg;
        pin_mv_next  = pin_mv_reg;

        case (s1_cmd_reg)
            CMD_TICK:
            begin
                if (enable_reg)
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            pstart_next = s1_now_reg;
                            cur_next    = '0;
                            avalid_next = 1'b0;
                            vend_next   = '0;
                            hend_next   = '0;
                            phase_next  = PH_WAIT;
                            pin_a_next  = 1'b0;
                            pin_b_next  = 1'b0;
                            pin_mv_next = 1'b0;
                        end
                        PH_WAIT:
                        begin
                            if (phase_exp)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else if (avalid_reg)
                            begin
                                pin_a_next   = reverse_reg;
                                pin_b_next   = !reverse_reg;
                                pin_mv_next  = 1'b1;
                                prev_next    = '0;
                                pstart_next  = s1_now_reg;
                                lchange_next = s1_now_reg;
                                phase_next   = PH_TO_V;
                            end
                        end
                        PH_TO_V, PH_TO_H:
                        begin
                            if (expired)
                            begin
                                if (phase_reg == PH_TO_V)
                                begin
                                    vend_next    = cur_reg;
                                    pin_a_next   = !reverse_reg;
                                    pin_b_next   = reverse_reg;
                                    pin_mv_next  = 1'b1;
                                    pstart_next  = s1_now_reg;
                                    lchange_next = s1_now_reg;
                                    phase_next   = PH_TO_H;
                                end
                                else
                                begin
                                    hend_next  = cur_reg;
                                    phase_next = PH_CAL;
                                end
                            end
                            else if (mot_abs > 18'(MOTION_STEP))
                            begin
                                // Still moving: restart the still-time window.
                                prev_next    = cur_reg;
                                lchange_next = s1_now_reg;
                            end
                        end
                        PH_CAL:
                        begin
                            // End-stop gap must lie near a quarter or three quarters of a turn.
                            if (gap > 18'd8000 && gap < 18'd10000)
                            begin
                                dir_next   = v_lt_h;
                                phase_next = PH_OK;
                            end
                            else if (gap > 18'd26000 && gap < 18'd28000)
                            begin
                                dir_next   = !v_lt_h;
                                phase_next = PH_OK;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_FAIL, PH_OK:
                        begin
                            // Bang-bang drive with a deadband; failure keeps the pins off.
                            if (phase_reg != PH_OK || drv_abs < 18'(DEADBAND))
                            begin
                                pin_a_next  = 1'b0;
                                pin_b_next  = 1'b0;
                                pin_mv_next = 1'b0;
                            end
                            else if ((!drv_d[ANGLE_W] && drv_d != '0) != !reverse_reg)
                            begin
                                pin_a_next  = 1'b1;
                                pin_b_next  = 1'b0;
                                pin_mv_next = 1'b1;
                            end
                            else
                            begin
                                pin_a_next  = 1'b0;
                                pin_b_next  = 1'b1;
                                pin_mv_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_SENSOR:
            begin
                avalid_next = 1'b1;
                if (phase_reg != PH_OK)
                begin
                    cur_next = s1_angle_reg;
                end
                else
                begin
                    cur_next = angle_t'(17'(signed'({1'b0, turn_rem})) - 17'sd18000);
                end
            end
            CMD_TARGET:
            begin
                target_next = s1_angle_reg;
            end
            CMD_RESTART:
            begin
                phase_next = PH_START;
            end
            default:
            begin
            end
        endcase
    end

    // State update, one item per cycle whenever the output register can take a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            cur_reg     <= '0;
            avalid_reg  <= 1'b0;
            prev_reg    <= '0;
            target_reg  <= '0;
            vend_reg    <= '0;
            hend_reg    <= '0;
            pstart_reg  <= '0;
            lchange_reg <= '0;
            dir_reg     <= 1'b0;
            pin_a_reg   <= 1'b0;
            pin_b_reg   <= 1'b0;
            pin_mv_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            avalid_reg  <= avalid_next;
            prev_reg    <= prev_next;
            target_reg  <= target_next;
            vend_reg    <= vend_next;
            hend_reg    <= hend_next;
            pstart_reg  <= pstart_next;
            lchange_reg <= lchange_next;
            dir_reg     <= dir_next;
            pin_a_reg   <= pin_a_next;
            pin_b_reg   <= pin_b_next;
            pin_mv_reg  <= pin_mv_next;
        end
    end

    // Output register: holds one result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_a_reg     <= pin_a_next;
            out_b_reg     <= pin_b_next;
            out_mv_reg    <= pin_mv_next;
            out_phase_reg <= phase_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.drive_a = out_a_reg;
    assign result.drive_b = out_b_reg;
    assign result.moving  = out_mv_reg;
    assign result.phase   = out_phase_reg;

    // The two bridge pins are never driven high together.
    assert property (@(posedge clk) disable iff (!rst_n) !(pin_a_reg && pin_b_reg))
        else $error("both H-bridge pins driven");

    // When no move is in progress both pins are off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pin_mv_reg |-> (!pin_a_reg && !pin_b_reg))
        else $error("pin driven while not moving");

    // Processing an item always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_reg)
        else $error("processed item produced no result");

    // The remap direction changes only when the calibrating phase is handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg != $past(dir_reg)) |-> ($past(phase_reg) == PH_CAL))
        else $error("direction changed outside calibration");

endmodule

`default_nettype wire

// ----- test/tb_hbridge_calibrate_and_drive_top.sv -----
// Testbench for the H-bridge calibrate-and-drive top level.
// Drives items and APB writes, predicts every result and checks it field by field.
// Depends on hbcd_pkg, the channel interfaces in hbcd_if.sv and the top module.
`default_nettype none

module tb_hbridge_calibrate_and_drive_top;
    import hbcd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUARTER_GAP  = TURN / 4;
    localparam int THREE_Q_GAP  = 3 * TURN / 4;
    localparam int GAP_TOL      = 1000;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic               drive_a;
        logic               drive_b;
        logic               moving;
        logic [PHASE_W-1:0] phase;
    } pin_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    hbcd_item_if   item_bus ();
    hbcd_result_if result_bus ();

    hbridge_calibrate_and_drive_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pin levels and phase expected for each transfer still in flight
    pin_phase_t pin_phase_q[$];
    int err_count = 0;
    int cycle_count = 0;

    // Stimulus controls, written only by the main sequence
    bit quiet_mode = 1'b0;
    int long_hold_ask = 0;
    logic [NOW_W-1:0] wall_ms = '0;
    int probe_angle = 0;

    // Receiver state, written only by the receiver process
    int long_hold_seen = 0;
    int rx_wait = 0;

    // Predicted configuration and controller state
    logic               cfg_enable  = 1'b0;
    logic               cfg_reverse = 1'b0;
    logic [TOUT_W-1:0]  cfg_timeout = 5'd15;
    logic [PHASE_W-1:0] seq_phase   = PH_START;
    int                 angle_now   = 0;
    int                 angle_last  = 0;
    int                 target_ang  = 0;
    int                 end_vert    = 0;
    int                 end_horiz   = 0;
    bit                 ang_seen    = 1'b0;
    bit                 sign_flip   = 1'b0;
    logic [NOW_W-1:0]   ts_phase    = '0;
    logic [NOW_W-1:0]   ts_motion   = '0;
    logic               pin_a       = 1'b0;
    logic               pin_b       = 1'b0;
    logic               pin_mv      = 1'b0;

    // Clock with a 20 unit period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        // Printing stops after a while so a broken block cannot flood the log.
        if (err_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic int rand_between(input int lo, input int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic set_pins(input logic a, input logic b, input logic mv);
        pin_a  = a;
        pin_b  = b;
        pin_mv = mv;
    endtask

    // A sensor change larger than the motion step restarts the still timer.
    task automatic track_motion(input logic [NOW_W-1:0] now);
        int d;
        d = angle_now - angle_last;
        if (d > MOTION_STEP || d < -MOTION_STEP)
        begin
            angle_last = angle_now;
            ts_motion  = now;
        end
    endtask

    // Advance the predicted controller by one accepted item and queue its result.
    task automatic step_hbridge(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now,
                                input angle_t ang);
        logic [NOW_W-1:0] limit;
        logic [NOW_W-1:0] since_phase;
        logic [NOW_W-1:0] since_motion;
        bit expired;
        int a;
        int gap;
        int rel;
        int m;
        int diff;
        a = ang;
        limit = 32'(MS_PER_S) * 32'(cfg_timeout);
        since_phase = now - ts_phase;
        since_motion = now - ts_motion;
        expired = (since_phase >= limit) || (since_motion >= 32'(STILL_MS));
        case (cmd)
            CMD_TICK:
            begin
                if (cfg_enable)
                begin
                    case (seq_phase)
                        PH_START:
                        begin
                            ts_phase  = now;
                            angle_now = 0;
                            ang_seen  = 1'b0;
                            end_vert  = 0;
                            end_horiz = 0;
                            seq_phase = PH_WAIT;
                            set_pins(1'b0, 1'b0, 1'b0);
                        end
                        PH_WAIT:
                        begin
                            if (since_phase >= limit)
                                seq_phase = PH_FAIL;
                            else if (ang_seen)
                            begin
                                set_pins(cfg_reverse, ~cfg_reverse, 1'b1);
                                angle_last = 0;
                                ts_phase   = now;
                                ts_motion  = now;
                                seq_phase  = PH_TO_V;
                            end
                        end
                        PH_TO_V:
                        begin
                            if (expired)
                            begin
                                end_vert = angle_now;
                                set_pins(~cfg_reverse, cfg_reverse, 1'b1);
                                ts_phase  = now;
                                ts_motion = now;
                                seq_phase = PH_TO_H;
                            end
                            else
                                track_motion(now);
                        end
                        PH_TO_H:
                        begin
                            if (expired)
                            begin
                                end_horiz = angle_now;
                                seq_phase = PH_CAL;
                            end
                            else
                                track_motion(now);
                        end
                        PH_CAL:
                        begin
                            // The end-stop gap picks the remap sign or fails the run.
                            gap = end_vert - end_horiz;
                            if (gap < 0)
                                gap = -gap;
                            if (gap - QUARTER_GAP < GAP_TOL && gap - QUARTER_GAP > -GAP_TOL)
                            begin
                                sign_flip = end_vert < end_horiz;
                                seq_phase = PH_OK;
                            end
                            else if (gap - THREE_Q_GAP < GAP_TOL &&
                                     gap - THREE_Q_GAP > -GAP_TOL)
                            begin
                                sign_flip = !(end_vert < end_horiz);
                                seq_phase = PH_OK;
                            end
                            else
                                seq_phase = PH_FAIL;
                        end
                        PH_FAIL, PH_OK:
                        begin
                            // Bang-bang drive with a deadband; a failed run stays off.
                            diff = target_ang - angle_now;
                            if (seq_phase != PH_OK || (diff < DEADBAND && diff > -DEADBAND))
                                set_pins(1'b0, 1'b0, 1'b0);
                            else if ((diff > 0) != (cfg_reverse == 1'b0))
                                set_pins(1'b1, 1'b0, 1'b1);
                            else
                                set_pins(1'b0, 1'b1, 1'b1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_SENSOR:
            begin
                ang_seen = 1'b1;
                if (seq_phase != PH_OK)
                    angle_now = a;
                else
                begin
                    // Remap relative to the horizontal end with a true modulo.
                    rel = sign_flip ? end_horiz - a : a - end_horiz;
                    m = (rel + TURN + HALF_TURN) % TURN;
                    if (m < 0)
                        m += TURN;
                    angle_now = m - HALF_TURN;
                end
            end
            CMD_TARGET:
                target_ang = a;
            CMD_RESTART:
                seq_phase = PH_START;
            default:
            begin
            end
        endcase
        pin_phase_q.push_back('{pin_a, pin_b, pin_mv, seq_phase});
    endtask

    // Offer one item, wait for its transfer, predict it, then idle a random while, none in quiet mode.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now,
                             input int ang);
        int gap;
        item_bus.valid   <= 1'b1;
        item_bus.command <= cmd;
        item_bus.now_ms  <= now;
        item_bus.angle   <= angle_t'(ang);
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        step_hbridge(cmd, now, angle_t'(ang));
        gap = quiet_mode ? 0 : gap_len();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick_after(input int lo, input int hi);
        wall_ms = wall_ms + $urandom_range(lo, hi);
        send_item(CMD_TICK, wall_ms, int'($urandom));
    endtask

    task automatic sense(input int ang);
        send_item(CMD_SENSOR, $urandom, ang);
        probe_angle = ang;
    endtask

    task automatic noise_item();
        send_item(CMD_W'($urandom_range(0, 3)), $urandom, rand_between(-65536, 65535));
    endtask

    // APB write: setup cycle, then access cycle; the caller returns the bus to idle.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_ENABLE:  cfg_enable  = value[0];
            REG_REVERSE: cfg_reverse = value[0];
            REG_TIMEOUT: cfg_timeout = value[TOUT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Drain every pending result, then write all three registers.
    task automatic reconfigure(input bit en, input bit rev, input int tout);
        item_bus.valid <= 1'b0;
        while (pin_phase_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
        write_reg(REG_ENABLE, DATA_W'(en));
        write_reg(REG_REVERSE, DATA_W'(rev));
        write_reg(REG_TIMEOUT, DATA_W'(tout));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sensor sweep toward an end stop, then a still stretch so the phase ends.
    task automatic sweep_to(input int dest);
        int steps;
        int from_ang;
        int settle;
        from_ang = probe_angle;
        steps = $urandom_range(2, 6);
        for (int k = 1; k <= steps; k++)
        begin
            sense(from_ang + (dest - from_ang) * k / steps + rand_between(-30, 30));
            if ($urandom_range(0, 11) == 0)
                noise_item();
            tick_after(50, 300);
        end
        settle = $urandom_range(3, 5);
        repeat (settle)
        begin
            if ($urandom_range(0, 1) == 1)
                sense(dest + rand_between(-5, 5));
            tick_after(300, 600);
        end
    endtask

    // Targets, sensor readings and ticks once calibration is over.
    task automatic drive_toward(input int count);
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: send_item(CMD_TARGET, $urandom, rand_between(-HALF_TURN, HALF_TURN - 1));
                1: send_item(CMD_TARGET, $urandom, angle_now + rand_between(-60, 60));
                2: sense(rand_between(0, TURN - 1));
                default: tick_after(1, 200);
            endcase
        end
    endtask

    task automatic test_directed();
        // Disabled: ticks do nothing, restart still lands, field extremes pass.
        send_item(CMD_TICK, 32'hFFFF_FFFF, 0);
        send_item(CMD_SENSOR, 32'h0, -65536);
        send_item(CMD_TARGET, 32'h0, 65535);
        send_item(CMD_RESTART, 32'h0, 0);
        // Zero timeout: the waiting phase fails at once, and failed keeps pins off.
        reconfigure(1'b1, 1'b0, 0);
        send_item(CMD_TICK, 32'd0, 0);
        send_item(CMD_TICK, 32'd5, 0);
        send_item(CMD_TICK, 32'd6, 0);
        // Full calibration at a timeout of 30 with a three-quarter-turn gap.
        reconfigure(1'b1, 1'b0, 30);
        send_item(CMD_RESTART, 32'd0, 0);
        send_item(CMD_TICK, 32'd1000, 0);
        send_item(CMD_TICK, 32'd1100, 0);
        send_item(CMD_SENSOR, 32'd0, 35999);
        send_item(CMD_TICK, 32'd1200, 0);
        send_item(CMD_SENSOR, 32'd0, 27000);
        send_item(CMD_TICK, 32'd1300, 0);
        send_item(CMD_TICK, 32'd2300, 0);
        send_item(CMD_SENSOR, 32'd0, 0);
        send_item(CMD_TICK, 32'd2400, 0);
        send_item(CMD_TICK, 32'd3400, 0);
        send_item(CMD_TICK, 32'd3500, 0);
        // Drive with an out of range sensor value, then the deadband edge.
        send_item(CMD_TARGET, 32'd0, HALF_TURN - 1);
        send_item(CMD_SENSOR, 32'd0, -65536);
        send_item(CMD_TICK, 32'd3600, 0);
        reconfigure(1'b1, 1'b1, 30);
        send_item(CMD_TICK, 32'd3700, 0);
        send_item(CMD_TARGET, 32'd0, angle_now + DEADBAND - 1);
        send_item(CMD_TICK, 32'd3800, 0);
        // Restart leaves the pins alone until the next tick.
        send_item(CMD_RESTART, 32'd0, 0);
        send_item(CMD_TICK, 32'd3900, 0);
    endtask

    task automatic test_calibration_runs(input int runs);
        int r;
        int tout;
        int v_end;
        int h_end;
        int gap;
        repeat (runs)
        begin
            r = $urandom_range(0, 9);
            tout = (r == 0) ? 0 : (r == 1) ? 30 : (r == 2) ? 1 : $urandom_range(2, 30);
            reconfigure($urandom_range(0, 9) != 0, $urandom_range(0, 1), tout);
            quiet_mode = ($urandom_range(0, 4) == 0);
            // Some runs cross the wrap of the millisecond counter.
            if ($urandom_range(0, 4) == 0)
                wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            else
                wall_ms = wall_ms + $urandom_range(0, 100000);
            // End stops near a quarter or three-quarter turn apart, or anywhere.
            v_end = rand_between(0, TURN - 1);
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = QUARTER_GAP + rand_between(-1200, 1200);
            else if (r < 8)
                gap = THREE_Q_GAP + rand_between(-1200, 1200);
            else
                gap = rand_between(0, TURN - 1);
            h_end = ($urandom_range(0, 1) == 1) ? v_end + gap : v_end - gap;
            if (h_end < 0 || h_end > TURN - 1)
                h_end = (h_end < 0) ? v_end + gap : v_end - gap;
            send_item(CMD_RESTART, $urandom, int'($urandom));
            tick_after(1, 50);
            if ($urandom_range(0, 3) == 0)
                tick_after(10, ($urandom_range(0, 1) == 1) ? 200 : 31000);
            sense(rand_between(0, TURN - 1));
            tick_after(10, 200);
            sweep_to(v_end);
            sweep_to(h_end);
            tick_after(10, 100);
            drive_toward($urandom_range(10, 20));
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver holds off long while items keep coming, so the input stalls.
    task automatic test_output_backpressure();
        reconfigure(1'b1, $urandom_range(0, 1), 30);
        quiet_mode = 1'b1;
        long_hold_ask++;
        drive_toward(40);
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_noise(input int count);
        reconfigure(1'b1, $urandom_range(0, 1), $urandom_range(0, 3));
        repeat (count) noise_item();
    endtask

    // Receiver: random stalls, none in quiet stretches, and a long hold on request.
    initial result_bus.ready = 1'b0;

    always @(posedge clk)
    begin
        if (long_hold_ask != long_hold_seen)
        begin
            long_hold_seen = long_hold_ask;
            rx_wait = LONG_HOLD;
        end
        if (rx_wait > 0)
        begin
            result_bus.ready <= 1'b0;
            rx_wait--;
        end
        else
        begin
            result_bus.ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 3) == 0)
                rx_wait = gap_len();
        end
    end

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        pin_phase_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pin_phase_q.size() == 0)
                report("result transfer with no prediction pending");
            else
            begin
                want = pin_phase_q.pop_front();
                if (result_bus.drive_a !== want.drive_a)
                    report($sformatf("drive_a got %b expected %b",
                                     result_bus.drive_a, want.drive_a));
                if (result_bus.drive_b !== want.drive_b)
                    report($sformatf("drive_b got %b expected %b",
                                     result_bus.drive_b, want.drive_b));
                if (result_bus.moving !== want.moving)
                    report($sformatf("moving got %b expected %b",
                                     result_bus.moving, want.moving));
                if (result_bus.phase !== want.phase)
                    report($sformatf("phase got %0d expected %0d",
                                     result_bus.phase, want.phase));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.command = CMD_TICK;
        item_bus.now_ms  = '0;
        item_bus.angle   = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_calibration_runs(30);
        test_output_backpressure();
        test_random_noise(150);

        item_bus.valid <= 1'b0;
        while (pin_phase_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/hbcd_pkg.sv
src/hbcd_if.sv
src/hbridge_calibrate_and_drive_top.sv
test/tb_hbridge_calibrate_and_drive_top.sv
